// ----- hw/rtl/kar_pkg.sv -----
// kar_pkg: shared types and constants for the key auto-repeat / long-press unit
// used by the channel interfaces, kar_core and the top level

package kar_pkg;

    // field widths
    localparam int unsigned KEYS_W  = 32;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned DELAY_W = 32;
    localparam int unsigned THRESH_W = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // register reset values
    localparam logic [DELAY_W-1:0]  DELAY_RST  = DELAY_W'(250 * 1000);
    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(8);
    localparam logic [KEYS_W-1:0]   MASK_RST   = 32'h0003_0000;

    // saturation limit of the repeat counter
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // event codes
    typedef enum logic [KIND_W-1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_LONG     = 2'd2,
        EV_REPEAT   = 2'd3
    } t_event_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY  = 2'd0,
        CFG_THRESH = 2'd1,
        CFG_MASK   = 2'd2
    } t_cfg_idx;

    // one poll of the button latch
    typedef struct packed {
        logic [KEYS_W-1:0] make_bits;
        logic [KEYS_W-1:0] break_bits;
        logic [KEYS_W-1:0] held_bits;
        logic [TIME_W-1:0] now_us;
    } t_poll;

    // configuration as seen by the core
    typedef struct packed {
        logic [DELAY_W-1:0]  repeat_delay_us;
        logic [THRESH_W-1:0] long_press_threshold;
        logic [KEYS_W-1:0]   ignore_mask;
    } t_cfg;

    // outcome of one poll
    typedef struct packed {
        logic              valid;
        t_event_kind       kind;
        logic [KEYS_W-1:0] key_snapshot;
    } t_result;

endpackage

// ----- hw/rtl/kar_ifs.sv -----
// kar_poll_if / kar_event_if: valid-ready channels of the key auto-repeat unit
// depends on kar_pkg for field widths

interface kar_poll_if;
    import kar_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEYS_W-1:0] make_bits;
    logic [KEYS_W-1:0] break_bits;
    logic [KEYS_W-1:0] held_bits;
    logic [TIME_W-1:0] now_us;

    modport source (output valid, make_bits, break_bits, held_bits, now_us, input ready);
    modport sink   (input valid, make_bits, break_bits, held_bits, now_us, output ready);
endinterface

interface kar_event_if;
    import kar_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [KEYS_W-1:0] key_snapshot;

    modport source (output valid, event_kind, key_snapshot, input ready);
    modport sink   (input valid, event_kind, key_snapshot, output ready);
endinterface

// ----- hw/rtl/kar_core.sv -----
// kar_core: key-down state, repeat timer and repeat counter; decides at most one event per poll
// depends on kar_pkg; state advances only when the top level retires the poll (i_fire)

module kar_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kar_pkg::t_poll  i_poll,
    input  kar_pkg::t_cfg   i_cfg,
    input  logic            i_fire,
    output kar_pkg::t_result o_res
);
    import kar_pkg::*;

    logic              r_key_down, n_key_down;
    logic [KEYS_W-1:0] r_stored, n_stored;
    logic [TIME_W-1:0] r_next_time, n_next_time;
    logic [CNT_W-1:0]  r_repeat_cnt, n_repeat_cnt;

    logic [TIME_W-1:0] rearm_time;
    logic              time_due;
    logic              keys_held;

    // shared datapath: re-arm sum, timer compare, held-key test
    assign rearm_time = i_poll.now_us + TIME_W'(i_cfg.repeat_delay_us);
    assign time_due   = (i_poll.now_us >= r_next_time);
    assign keys_held  = ((i_poll.held_bits & ~i_cfg.ignore_mask) != '0);

    // event decision, press has priority over release over repeat
    always_comb begin
        n_key_down   = r_key_down;
        n_stored     = r_stored;
        n_next_time  = r_next_time;
        n_repeat_cnt = r_repeat_cnt;
        o_res.valid  = 1'b0;
        o_res.kind   = EV_PRESSED;
        if (i_poll.make_bits != '0) begin
            n_stored     = i_poll.held_bits;
            n_repeat_cnt = '0;
            n_next_time  = rearm_time;
            n_key_down   = 1'b1;
            o_res.valid  = 1'b1;
            o_res.kind   = EV_PRESSED;
        end else if (i_poll.break_bits != '0) begin
            if (r_key_down) begin
                n_next_time = '0;
                n_key_down  = 1'b0;
                o_res.valid = 1'b1;
                o_res.kind  = (r_repeat_cnt >= i_cfg.long_press_threshold) ?
                              EV_LONG : EV_RELEASED;
            end
        end else if (keys_held && r_key_down && time_due) begin
            if (r_repeat_cnt != CNT_MAX) begin
                n_repeat_cnt = r_repeat_cnt + CNT_W'(1);
            end
            n_next_time = rearm_time;
            o_res.valid = 1'b1;
            o_res.kind  = EV_REPEAT;
        end
        o_res.key_snapshot = n_stored;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down   <= 1'b0;
            r_stored     <= '0;
            r_next_time  <= '0;
            r_repeat_cnt <= '0;
        end else if (i_fire) begin
            r_key_down   <= n_key_down;
            r_stored     <= n_stored;
            r_next_time  <= n_next_time;
            r_repeat_cnt <= n_repeat_cnt;
        end
    end

    // a press always leaves the unit in key-down mode with a cleared count
    a_press_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_poll.make_bits != '0) |=> r_key_down && (r_repeat_cnt == '0))
        else $error("press did not arm key-down mode");

    // the repeat count only moves upward between presses
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_poll.make_bits == '0) |=> r_repeat_cnt >= $past(r_repeat_cnt))
        else $error("repeat count went down without a press");

    // a repeat or release event needs the key to be down
    a_event_needs_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.kind != EV_PRESSED) |-> r_key_down)
        else $error("event reported while idle");

    // leaving key-down mode clears the repeat timer
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_key_down && !n_key_down |=> r_next_time == '0)
        else $error("release left the repeat timer armed");

endmodule

// ----- hw/rtl/key_autorepeat_long_press_unit.sv -----
// key_autorepeat_long_press_unit: top level of the key auto-repeat / long-press unit
// depends on kar_pkg, kar_poll_if / kar_event_if and kar_core
//
//  channel   dir  handshake     word
//  i_in      in   valid/ready   make_bits, break_bits, held_bits, now_us
//  o_out     out  valid/ready   event_kind, key_snapshot
//  i_cfg_*   in   write enable  index, 32-bit data (no read-back)
//
// one poll per cycle sustained while the result slot frees; the event word is offered
// after the poll is accepted (input register, then event logic into the result register)
// reset (synchronous, active low) puts the unit idle with register defaults
// a poll that gives no event retires even while a result waits downstream;
// a poll that gives an event waits in the input register until the result slot frees

module key_autorepeat_long_press_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    kar_poll_if.sink                           i_in,
    kar_event_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [kar_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kar_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import kar_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_poll   r_in;
    logic    r_out_valid;
    t_event_kind       r_out_kind;
    logic [KEYS_W-1:0] r_out_keys;

    t_result core_res;
    logic    slot_free;
    logic    fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay_us      <= DELAY_RST;
            r_cfg.long_press_threshold <= THRESH_RST;
            r_cfg.ignore_mask          <= MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY:  r_cfg.repeat_delay_us      <= i_cfg_data[DELAY_W-1:0];
                CFG_THRESH: r_cfg.long_press_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_MASK:   r_cfg.ignore_mask          <= i_cfg_data[KEYS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    assign slot_free  = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && (!core_res.valid || slot_free);
    assign i_in.ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.make_bits  <= i_in.make_bits;
            r_in.break_bits <= i_in.break_bits;
            r_in.held_bits  <= i_in.held_bits;
            r_in.now_us     <= i_in.now_us;
        end
    end

    // event logic and key state
    kar_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (r_in),
        .i_cfg   (r_cfg),
        .i_fire  (fire),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_res.valid) begin
            r_out_kind <= core_res.kind;
            r_out_keys <= core_res.key_snapshot;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out_kind;
    assign o_out.key_snapshot = r_out_keys;

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for key_autorepeat_long_press_unit, a press / repeat / long-press tracker
// depends on kar_pkg, kar_poll_if / kar_event_if and the unit itself; drives polls and checks
// every event word against a cycle-free model of the repeat state
`timescale 1ns / 1ps

module tb;
    import kar_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned MAX_SHOWN   = 10;

    // expected event word
    typedef struct {
        t_event_kind       kind;
        logic [KEYS_W-1:0] keys;
    } t_key_event;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    kar_poll_if  poll_ch ();
    kar_event_if evt_ch ();

    key_autorepeat_long_press_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (poll_ch),
        .o_out      (evt_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // model copy of the registers
    logic [DELAY_W-1:0]  cf_delay;
    logic [THRESH_W-1:0] cf_thresh;
    logic [KEYS_W-1:0]   cf_mask;

    // model copy of the repeat state
    logic                pr_down;
    logic [KEYS_W-1:0]   pr_keys;
    logic [TIME_W-1:0]   pr_next_us;
    logic [CNT_W-1:0]    pr_repeats;

    t_key_event pending_events[$];
    t_key_event head_ev;

    logic [TIME_W-1:0] clock_us;
    int unsigned polls_sent;
    int unsigned fail_count;
    int unsigned kind_count[4];
    int unsigned idle_cycles;
    int unsigned sink_hold_left;
    bit          src_idle_en;
    bit          snk_idle_en;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void report_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("%s", msg);
    endfunction

    // model of one poll, queues the event it causes
    function automatic void predict_poll(input logic [KEYS_W-1:0] mk, input logic [KEYS_W-1:0] brk,
                                         input logic [KEYS_W-1:0] held,
                                         input logic [TIME_W-1:0] t);
        t_key_event ev;
        bit fire;
        fire = 1'b0;
        ev.kind = EV_PRESSED;
        if (mk != '0) begin
            // press wins over release and hold in the same poll
            pr_keys    = held;
            pr_repeats = '0;
            pr_next_us = t + {32'b0, cf_delay};
            pr_down    = 1'b1;
            ev.kind    = EV_PRESSED;
            fire       = 1'b1;
        end else if (brk != '0) begin
            if (pr_down) begin
                pr_next_us = '0;
                if (pr_repeats >= cf_thresh) ev.kind = EV_LONG;
                else ev.kind = EV_RELEASED;
                pr_down = 1'b0;
                fire    = 1'b1;
            end
        end else if (pr_down && (held & ~cf_mask) != '0 && t >= pr_next_us) begin
            if (pr_repeats != CNT_MAX) pr_repeats = pr_repeats + CNT_W'(1);
            pr_next_us = t + {32'b0, cf_delay};
            ev.kind    = EV_REPEAT;
            fire       = 1'b1;
        end
        if (fire) begin
            ev.keys = pr_keys;
            pending_events.push_back(ev);
        end
    endfunction

    // time step for a poll, scaled to the current delay
    function automatic logic [TIME_W-1:0] pick_advance();
        case ($urandom_range(3))
            0: return {32'b0, 32'($urandom_range(0, cf_delay >> 1))};
            1: return {32'b0, 32'($urandom_range(0, 20))};
            default: return {32'b0, cf_delay} + {32'b0, 32'($urandom_range(0, 50))};
        endcase
    endfunction

    // send one poll word; called and returns at a falling edge
    task automatic send_poll(input logic [KEYS_W-1:0] mk, input logic [KEYS_W-1:0] brk,
                             input logic [KEYS_W-1:0] held, input logic [TIME_W-1:0] adv);
        bit done;
        done = 1'b0;
        clock_us = clock_us + adv;
        while (src_idle_en && $urandom_range(99) < 28) begin
            poll_ch.valid <= 1'b0;
            @(negedge clk);
        end
        poll_ch.valid      <= 1'b1;
        poll_ch.make_bits  <= mk;
        poll_ch.break_bits <= brk;
        poll_ch.held_bits  <= held;
        poll_ch.now_us     <= clock_us;
        while (!done) begin
            @(posedge clk);
            if (poll_ch.ready) begin
                done = 1'b1;
                polls_sent++;
                predict_poll(mk, brk, held, clock_us);
            end
            @(negedge clk);
        end
    endtask

    // stop sending and wait for every expected event word
    task automatic drain_events();
        poll_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write all three registers; only while the unit is idle
    task automatic set_config(input logic [DELAY_W-1:0] dly, input logic [THRESH_W-1:0] thr,
                              input logic [KEYS_W-1:0] msk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DELAY;
        cfg_data <= dly;
        @(negedge clk);
        cfg_idx  <= CFG_THRESH;
        cfg_data <= {24'b0, thr};
        @(negedge clk);
        cfg_idx  <= CFG_MASK;
        cfg_data <= msk;
        @(negedge clk);
        cfg_we <= 1'b0;
        cf_delay  = dly;
        cf_thresh = thr;
        cf_mask   = msk;
    endtask

    // directed cases at the reset register values
    task automatic test_reset_defaults();
        clock_us = 64'd1000;
        send_poll('0, '0, 32'h1, 0);                     // hold while idle
        send_poll('0, 32'h1, '0, 0);                     // release while idle
        send_poll(32'h1, '0, 32'h5, 0);                  // press
        send_poll('0, '0, 32'h5, 100);                   // hold before repeat time
        send_poll('0, '0, 32'h5, 249900);                // hold exactly at repeat time
        send_poll('0, '0, 32'h0003_0000, 300000);        // only ignored keys held
        send_poll('0, '0, 32'h5, 0);                     // repeat after ignored poll
        send_poll(32'h2, 32'h1, '1, 10);                 // press and release together
        send_poll('0, '1, '0, 10);                       // short release
        send_poll('1, '1, '0, 0);                        // all-ones press, nothing held
        send_poll('0, '0, '0, 64'd1_000_000);            // nothing held
        send_poll('0, 32'h8000_0000, '0, 0);             // release
        // repeat time wraps past the top of the clock
        clock_us = '1 - 64'd5;
        send_poll(32'h8000_0000, '0, 32'h1, 0);
        send_poll('0, '0, 32'h1, 0);
        send_poll('0, '0, 32'h1, 2);
        send_poll('0, 32'h1, '0, 10);
        drain_events();
    endtask

    // register extremes: zero threshold, all-ignored mask, largest delay
    task automatic test_config_extremes();
        clock_us = 64'd5000;
        set_config('0, '0, '0);
        send_poll(32'h1, '0, 32'h1, 0);
        send_poll('0, 32'h1, '0, 0);                     // long press with no repeats
        send_poll(32'h4, '0, 32'h4, 1);
        send_poll('0, '0, 32'h4, 0);
        send_poll('0, 32'h4, '0, 0);
        drain_events();
        set_config('1, 8'hFF, '1);
        send_poll(32'h1, '0, '1, 0);
        send_poll('0, '0, '1, 64'h1_0000_0000);          // everything ignored
        send_poll('0, '1, '0, 0);
        drain_events();
        set_config(32'd3, 8'd2, '0);
        send_poll(32'h10, '0, 32'h10, 0);
        repeat (3) send_poll('0, '0, 32'h10, 3);
        send_poll('0, 32'h10, 32'h10, 1);                // long press after three repeats
        drain_events();
    endtask

    // repeat counter sticks at its top value; both sides run without idling
    task automatic test_count_saturation();
        set_config('0, 8'hFF, '0);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_poll(32'h1, '0, 32'h3, 0);
        repeat (258) send_poll('0, '0, 32'h3, 1);
        send_poll('0, 32'h1, '0, 1);
        drain_events();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // receiver holds off while every poll makes a repeat, then the sender waits for all
    task automatic test_backpressure();
        set_config('0, 8'd4, '0);
        src_idle_en = 1'b0;
        send_poll(32'h1, '0, 32'hF, 0);
        sink_hold_left = 150;
        repeat (60) send_poll('0, '0, 32'hF, 1);
        drain_events();
        send_poll('0, 32'h1, '0, 0);
        drain_events();
    endtask

    // random press / hold / release sequences over several register settings
    task automatic test_random_sequences();
        int unsigned target;
        logic [DELAY_W-1:0]  dly;
        logic [THRESH_W-1:0] thr;
        logic [KEYS_W-1:0]   msk;
        logic [KEYS_W-1:0]   held;
        for (int phase = 0; phase < 10; phase++) begin
            src_idle_en = (phase != 0);
            snk_idle_en = (phase != 0);
            if (phase == 0) begin
                dly = 32'd100;
                thr = 8'd2;
                msk = MASK_RST;
            end else begin
                case ($urandom_range(4))
                    0: dly = '0;
                    1: dly = $urandom_range(1, 1000);
                    2: dly = DELAY_RST;
                    3: dly = '1;
                    default: dly = $urandom;
                endcase
                case ($urandom_range(4))
                    0: thr = '0;
                    1, 2: thr = THRESH_W'($urandom_range(1, 4));
                    3: thr = 8'hFF;
                    default: thr = THRESH_W'($urandom_range(0, 255));
                endcase
                case ($urandom_range(3))
                    0: msk = '0;
                    1: msk = MASK_RST;
                    2: msk = '1;
                    default: msk = $urandom;
                endcase
            end
            set_config(dly, thr, msk);
            target = polls_sent + 15;
            while (polls_sent < target) begin
                if ($urandom_range(99) < 15) begin
                    // noise poll, sometimes with a jump anywhere in time
                    send_poll($urandom_range(1) ? $urandom : 32'h0,
                              $urandom_range(1) ? $urandom : 32'h0, $urandom,
                              ($urandom_range(9) == 0) ? {$urandom, $urandom} : pick_advance());
                end else begin
                    // well-formed sequence
                    send_poll($urandom | (32'h1 << $urandom_range(31)),
                              $urandom_range(1) ? $urandom : 32'h0, $urandom, pick_advance());
                    repeat ($urandom_range(0, 10)) begin
                        held = ($urandom_range(4) == 0) ? ($urandom & cf_mask) : $urandom;
                        send_poll('0, '0, held, pick_advance());
                    end
                    if ($urandom_range(4) != 0)
                        send_poll('0, $urandom | (32'h1 << $urandom_range(31)), $urandom,
                                  pick_advance());
                end
            end
            drain_events();
        end
    endtask

    // receiver: random stalls plus a counted hold-off on request
    always @(negedge clk) begin
        if (sink_hold_left != 0) begin
            evt_ch.ready <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else if (snk_idle_en && $urandom_range(99) < 28) begin
            evt_ch.ready <= 1'b0;
        end else begin
            evt_ch.ready <= 1'b1;
        end
    end

    // compare each event word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && evt_ch.valid && evt_ch.ready) begin
            kind_count[evt_ch.event_kind]++;
            if (pending_events.size() == 0) begin
                report_error($sformatf("unexpected event: kind %0d keys %h",
                                       evt_ch.event_kind, evt_ch.key_snapshot));
            end else begin
                head_ev = pending_events.pop_front();
                if (evt_ch.event_kind !== head_ev.kind || evt_ch.key_snapshot !== head_ev.keys)
                    report_error($sformatf("mismatch: expected kind %0d keys %h, got kind %0d keys %h",
                                           head_ev.kind, head_ev.keys,
                                           evt_ch.event_kind, evt_ch.key_snapshot));
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (poll_ch.valid && poll_ch.ready) ||
            (evt_ch.valid && evt_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
            $display("key_autorepeat_long_press_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_DELAY;
        cfg_data           = '0;
        poll_ch.valid      = 1'b0;
        poll_ch.make_bits  = '0;
        poll_ch.break_bits = '0;
        poll_ch.held_bits  = '0;
        poll_ch.now_us     = '0;
        evt_ch.ready       = 1'b0;
        cf_delay    = DELAY_RST;
        cf_thresh   = THRESH_RST;
        cf_mask     = MASK_RST;
        pr_down     = 1'b0;
        pr_keys     = '0;
        pr_next_us  = '0;
        pr_repeats  = '0;
        clock_us    = '0;
        polls_sent  = 0;
        fail_count  = 0;
        idle_cycles = 0;
        sink_hold_left = 0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int k = 0; k < 4; k++) kind_count[k] = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_count_saturation();
        test_backpressure();
        test_random_sequences();

        drain_events();
        repeat (10) @(posedge clk);
        if (pending_events.size() != 0)
            report_error($sformatf("%0d expected events never arrived", pending_events.size()));
        $display("covered %0d polls: %0d pressed, %0d released, %0d long press, %0d repeat events",
                 polls_sent, kind_count[EV_PRESSED], kind_count[EV_RELEASED],
                 kind_count[EV_LONG], kind_count[EV_REPEAT]);
        $display("directed edges, counter saturation, output hold-off, 10 register settings");
        if (fail_count == 0) begin
            $display("key_autorepeat_long_press_unit test passed");
        end else begin
            $display("%0d failures", fail_count);
            $display("key_autorepeat_long_press_unit test failed");
        end
        $finish;
    end

endmodule
